[sv/minv_pkg.sv]
// Shared constants for the 3x3 matrix inverse: element count and the
// operand index tables for the adjugate cofactors. No dependencies.
package minv_pkg;

  localparam int NumElems = 9;
  localparam int Dim      = 3;

  // Cofactor e = p(A)*p(B) - p(C)*p(D), elements indexed row*3+col,
  // already transposed so that entry e is adjugate row e/3, column e%3.
  localparam int CofIdxA [NumElems] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
  localparam int CofIdxB [NumElems] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
  localparam int CofIdxC [NumElems] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
  localparam int CofIdxD [NumElems] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

endpackage

[sv/minv_in_if.sv]
// Input channel of the 3x3 matrix inverse: valid/ready plus nine matrix
// elements. No dependencies.
interface minv_in_if #(parameter int ELEM_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] in00, in01, in02;
  logic signed [ELEM_WIDTH-1:0] in10, in11, in12;
  logic signed [ELEM_WIDTH-1:0] in20, in21, in22;

  modport source (output valid, in00, in01, in02, in10, in11, in12, in20, in21, in22,
                  input ready);
  modport sink (input valid, in00, in01, in02, in10, in11, in12, in20, in21, in22,
                output ready);
endinterface

[sv/minv_out_if.sv]
// Output channel of the 3x3 matrix inverse: valid/ready plus nine inverse
// elements and the singular flag. No dependencies.
interface minv_out_if #(parameter int ELEM_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] out00, out01, out02;
  logic signed [ELEM_WIDTH-1:0] out10, out11, out12;
  logic signed [ELEM_WIDTH-1:0] out20, out21, out22;
  logic                         singular;

  modport source (output valid, out00, out01, out02, out10, out11, out12, out20, out21,
                  out22, singular, input ready);
  modport sink (input valid, out00, out01, out02, out10, out11, out12, out20, out21,
                out22, singular, output ready);
endinterface

[sv/matrix_inverse_3x3.sv]
// 3x3 fixed-point matrix inverse by the adjugate, fully pipelined.
// Depends on minv_pkg, minv_in_if and minv_out_if.
//
// Usage: one 3x3 matrix of signed fixed-point elements (ELEM_WIDTH bits,
// FRAC_BITS fraction bits) is taken on in_ch per transfer, and its inverse
// leaves on out_ch as one transfer, rounded to nearest with ties away from
// zero and saturated to the element range. A zero determinant raises
// singular and gives all-zero elements.
// The register stages run in order: four stages of multiplies and sums
// for cofactors and determinant, one for absolute values, one for the
// overflow test, ELEM_WIDTH-1 restoring division stages (one quotient
// bit each) and the output register. Throughput is one matrix per cycle
// unless the receiver stalls; the division pipeline sets the depth.
// Reset clears every valid bit, so the pipe comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready falls; nothing is dropped or repeated.
module matrix_inverse_3x3 #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  minv_in_if.sink    in_ch,
  minv_out_if.source out_ch
);
  import minv_pkg::*;

  localparam int E   = ELEM_WIDTH;
  localparam int PW  = 2 * E;             // element product
  localparam int CW  = 2 * E + 1;         // cofactor
  localparam int TW  = 2 * E + 1;         // determinant partial product
  localparam int DW  = 3 * E + 3;         // determinant
  localparam int NW0 = 2 * E + 2 * FRAC_BITS + 3;
  localparam int NW1 = 3 * E + 4 + E;
  localparam int RW  = (NW0 > NW1) ? NW0 : NW1;  // numerator and remainder
  localparam int QW  = E - 1;             // quotient bits before saturation
  localparam int NDS = E;                 // division register slots
  localparam int L   = E + 6;             // total register stages

  logic adv;
  logic [L-1:0] vld;

  // The pipeline moves whenever the output register is empty or drained.
  assign adv         = !vld[L-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_ch.valid};
    end
  end

  logic signed [E-1:0] a [NumElems];
  assign a[0] = in_ch.in00;
  assign a[1] = in_ch.in01;
  assign a[2] = in_ch.in02;
  assign a[3] = in_ch.in10;
  assign a[4] = in_ch.in11;
  assign a[5] = in_ch.in12;
  assign a[6] = in_ch.in20;
  assign a[7] = in_ch.in21;
  assign a[8] = in_ch.in22;

  // Stage 1: the eighteen element products; column 0 travels alongside.
  logic signed [PW-1:0] p1 [NumElems];
  logic signed [PW-1:0] p2 [NumElems];
  logic signed [E-1:0]  col1 [Dim];
  // Stage 2: cofactors.
  logic signed [CW-1:0] adj2 [NumElems];
  logic signed [E-1:0]  col2 [Dim];
  // Stage 3: determinant partial products, split over the cofactor halves.
  logic signed [TW-1:0] plo [Dim];
  logic signed [TW-1:0] phi [Dim];
  logic signed [CW-1:0] adj3 [NumElems];
  // Stage 4: determinant.
  logic signed [DW-1:0] det4;
  logic signed [CW-1:0] adj4 [NumElems];
  logic signed [DW-1:0] det_sum;

  always_comb begin
    det_sum = '0;
    for (int i = 0; i < Dim; i++) begin
      det_sum = det_sum + (DW'(phi[i]) <<< E) + DW'(plo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NumElems; e++) begin
        p1[e]   <= a[CofIdxA[e]] * a[CofIdxB[e]];
        p2[e]   <= a[CofIdxC[e]] * a[CofIdxD[e]];
        adj2[e] <= {p1[e][PW-1], p1[e]} - {p2[e][PW-1], p2[e]};
        adj3[e] <= adj2[e];
        adj4[e] <= adj3[e];
      end
      for (int i = 0; i < Dim; i++) begin
        col1[i] <= a[i * Dim];
        col2[i] <= col1[i];
        plo[i]  <= col2[i] * $signed({1'b0, adj2[i][E-1:0]});
        phi[i]  <= col2[i] * $signed(adj2[i][CW-1:E]);
      end
      det4 <= det_sum;
    end
  end

  // Stage 5: magnitudes, signs and the rounding offset. The numerator is
  // |cof|*2^(2F+1) + |det| over 2|det|, which rounds halves away from zero.
  logic [DW-1:0] det_abs;
  logic [RW-1:0] num5 [NumElems];
  logic [RW-1:0] den5;
  logic          neg5 [NumElems];
  logic          zero5;

  assign det_abs = det4[DW-1] ? DW'(-det4) : DW'(det4);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NumElems; e++) begin
        num5[e] <= (RW'(adj4[e][CW-1] ? CW'(-adj4[e]) : CW'(adj4[e])) << (2 * FRAC_BITS + 1))
                   + RW'(det_abs);
        neg5[e] <= adj4[e][CW-1] ^ det4[DW-1];
      end
      den5  <= RW'(det_abs) << 1;
      zero5 <= (det4 == '0);
    end
  end

  // Stage 6 and the division stages share slot arrays: slot 0 holds the
  // overflow test, slot s+1 the result of quotient bit E-2-s.
  logic [RW-1:0] rem  [NDS][NumElems];
  logic [QW-1:0] quo  [NDS][NumElems];
  logic          big  [NDS][NumElems];
  logic          sgn  [NDS][NumElems];
  logic [RW-1:0] dvs  [NDS];
  logic          zro  [NDS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NumElems; e++) begin
        rem[0][e] <= num5[e];
        quo[0][e] <= '0;
        big[0][e] <= num5[e] >= (den5 << QW);
        sgn[0][e] <= neg5[e];
      end
      dvs[0] <= den5;
      zro[0] <= zero5;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [RW-1:0] shifted;
    assign shifted = dvs[s] << K;

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int e = 0; e < NumElems; e++) begin
          if (rem[s][e] >= shifted) begin
            rem[s+1][e]    <= rem[s][e] - shifted;
            quo[s+1][e]    <= quo[s][e] | (QW'(1) << K);
          end else begin
            rem[s+1][e]    <= rem[s][e];
            quo[s+1][e]    <= quo[s][e];
          end
          big[s+1][e] <= big[s][e];
          sgn[s+1][e] <= sgn[s][e];
        end
        dvs[s+1] <= dvs[s];
        zro[s+1] <= zro[s];
      end
    end
  end

  // Output register: saturate, apply the sign, clear on a singular matrix.
  localparam logic [E-1:0] MinMag = E'(1) << (E - 1);

  logic [E-1:0] res  [NumElems];
  logic [E-1:0] res_next [NumElems];
  logic         sing;

  always_comb begin
    for (int e = 0; e < NumElems; e++) begin
      logic [E-1:0] mag;
      mag = big[NDS-1][e] ? (sgn[NDS-1][e] ? MinMag : MinMag - E'(1))
                          : {1'b0, quo[NDS-1][e]};
      res_next[e] = zro[NDS-1] ? '0 : (sgn[NDS-1][e] ? E'(-mag) : mag);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res  <= res_next;
      sing <= zro[NDS-1];
    end
  end

  assign out_ch.valid    = vld[L-1];
  assign out_ch.out00    = res[0];
  assign out_ch.out01    = res[1];
  assign out_ch.out02    = res[2];
  assign out_ch.out10    = res[3];
  assign out_ch.out11    = res[4];
  assign out_ch.out12    = res[5];
  assign out_ch.out20    = res[6];
  assign out_ch.out21    = res[7];
  assign out_ch.out22    = res[8];
  assign out_ch.singular = sing;

  a_singular_zero : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.singular |-> res[0] == '0 && res[4] == '0 && res[8] == '0
      && res[1] == '0 && res[2] == '0 && res[3] == '0 && res[5] == '0
      && res[6] == '0 && res[7] == '0)
    else $error("singular result with nonzero elements");

  a_stall_only_backpressure : assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without output back-pressure");

  a_empty_after_reset : assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result offered straight after reset");

endmodule
